// ===== hdl/ttv_pkg.sv =====
// ----------------------------------------------------------------------------
// ttv_pkg: shared types and constants of the triangle tangent vector unit
// Field widths, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package ttv_pkg;

    localparam int MaxVerticesDefault = 65536;
    localparam int CoordBitsDefault   = 16;
    localparam int FieldBits          = 16;
    localparam int IndexBits          = 16;
    localparam int OutBits            = 16;
    localparam int StatusBits         = 2;
    // widest T magnitude: 2*(2^CB)^2 < 2^66 at CB=32, keep one spare bit
    localparam int TanBits            = 68;
    localparam int SqBits             = 62;   // mag < 2^30, sum of 3 squares < 2^62
    localparam int SumBits            = 64;

    localparam logic [StatusBits-1:0] StatOk      = 2'd0;
    localparam logic [StatusBits-1:0] StatDetZero = 2'd1;
    localparam logic [StatusBits-1:0] StatLenZero = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [1:0]            sel;
    } mul_ctl_t;

endpackage

// ===== hdl/ttv_if.sv =====
// ----------------------------------------------------------------------------
// ttv_if: valid/ready channel interfaces
// Corner request channel and tangent result channel.
// ----------------------------------------------------------------------------
interface ttv_corner_if;
    logic                           valid;
    logic                           ready;
    logic [ttv_pkg::IndexBits-1:0]  vtx_index;
    logic [ttv_pkg::FieldBits-1:0]  pos_x;
    logic [ttv_pkg::FieldBits-1:0]  pos_y;
    logic [ttv_pkg::FieldBits-1:0]  pos_z;
    logic [ttv_pkg::FieldBits-1:0]  tex_u;
    logic [ttv_pkg::FieldBits-1:0]  tex_v;
    modport source (output valid, vtx_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                    input ready);
    modport sink   (input valid, vtx_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                    output ready);
endinterface

interface ttv_tangent_if;
    logic                           valid;
    logic                           ready;
    logic [ttv_pkg::IndexBits-1:0]  out_vertex;
    logic [ttv_pkg::OutBits-1:0]    tan_x;
    logic [ttv_pkg::OutBits-1:0]    tan_y;
    logic [ttv_pkg::OutBits-1:0]    tan_z;
    logic [ttv_pkg::StatusBits-1:0] status;
    logic                           last;
    modport source (output valid, out_vertex, tan_x, tan_y, tan_z, status, last,
                    input ready);
    modport sink   (input valid, out_vertex, tan_x, tan_y, tan_z, status, last,
                    output ready);
endinterface

// ===== hdl/triangle_tangent_vector_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_vector_unit: per-triangle unit tangent
// Holds two corners, on the third forms T, normalizes it to Q1.14 and
// sends three tangent results, one per corner.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                       | handshake
//  corner   | in  | vtx_index, pos_x/y/z, tex_u/v                 | valid/ready
//  tangent  | out | out_vertex, tan_x/y/z, status, last           | valid/ready
//
//  First two corners of a triangle are held as they are taken. The third
//  corner runs 8 shift-add products (T and determinant) on the shared
//  multiplier; the index reduction modulo MAX_VERTICES runs bit-serially
//  under them. An ok triangle adds a scale loop, three squares, a square
//  root and three divisions. Results go out one per accepted cycle; a stall
//  holds them. Reset clears the corner count and the sequencer; held corners
//  need none.
// ----------------------------------------------------------------------------
module triangle_tangent_vector_unit #(
    parameter int MAX_VERTICES = ttv_pkg::MaxVerticesDefault,
    parameter int COORD_BITS   = ttv_pkg::CoordBitsDefault
) (
    input  logic clk,
    input  logic rst_n,
    ttv_corner_if.sink    corner,
    ttv_tangent_if.source tangent
);
    // fields are 16 bits; wider coordinates read the field as unsigned
    localparam int CB   = (COORD_BITS > 16) ? 17 : COORD_BITS;
    localparam int DB   = CB + 1;           // delta width, signed
    localparam int MB   = DB;               // delta magnitude width
    localparam int PB   = 2 * MB;           // product width
    localparam int TB   = ttv_pkg::TanBits;
    localparam int IdxB = ttv_pkg::IndexBits;
    localparam logic [IdxB:0] VertMod =
        (MAX_VERTICES >= 65536) ? {1'b1, {IdxB{1'b0}}} : (IdxB+1)'(MAX_VERTICES);

    logic signed [CB-1:0] hp_reg [2][3];
    logic signed [CB-1:0] ht_reg [2][2];
    logic [IdxB-1:0]      hi_reg [2];
    logic [1:0]           cc_reg, cc_next;
    ttv_pkg::state_t      st_reg, st_next;

    logic signed [DB-1:0] dp1_reg [3], dp2_reg [3];
    logic signed [DB-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [TB-1:0] t_reg [3];
    logic signed [TB-1:0] det_reg, det_next;
    logic [3:0]           step_reg, step_next;   // product step 0..7
    logic [1:0]           k_reg, k_next;
    logic [TB-1:0]        mag_reg [3];
    logic [ttv_pkg::SumBits-1:0] sum_reg;
    logic [31:0]          len_reg;
    logic [15:0]          res_reg [3];
    logic [ttv_pkg::StatusBits-1:0] status_reg, status_next;

    logic                 take;
    logic signed [CB-1:0] cp [3];
    logic signed [CB-1:0] ct [2];

    assign cp[0] = CB'(corner.pos_x);
    assign cp[1] = CB'(corner.pos_y);
    assign cp[2] = CB'(corner.pos_z);
    assign ct[0] = CB'(corner.tex_u);
    assign ct[1] = CB'(corner.tex_v);

    assign corner.ready = (st_reg == ttv_pkg::ST_IDLE);
    assign take = corner.valid && corner.ready;

    // ---------------- shared multiplier ----------------
    logic              mul_start, mul_done;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;
    logic signed [DB-1:0] op_a, op_b;
    logic              neg_prod;

    ttv_serial_mul #(.ABits(32), .BBits(32)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .product(mul_p)
    );

    // recurrence unit
    logic        sd_sqrt, sd_div, sd_done;
    logic [31:0] sd_res;

    ttv_sqrt_div u_sd (
        .clk(clk), .rst_n(rst_n), .start_sqrt(sd_sqrt), .start_div(sd_div),
        .radicand(sum_reg), .dividend_mag(mag_reg[k_reg][31:0]),
        .divisor(len_reg), .done(sd_done), .result(sd_res)
    );

    // product schedule: steps 0..5 = T axis terms, 6..7 = det terms
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            4'd0: begin op_a = dp1_reg[0]; op_b = dv2_reg; end
            4'd1: begin op_a = dp2_reg[0]; op_b = dv1_reg; end
            4'd2: begin op_a = dp1_reg[1]; op_b = dv2_reg; end
            4'd3: begin op_a = dp2_reg[1]; op_b = dv1_reg; end
            4'd4: begin op_a = dp1_reg[2]; op_b = dv2_reg; end
            4'd5: begin op_a = dp2_reg[2]; op_b = dv1_reg; end
            4'd6: begin op_a = du1_reg;    op_b = dv2_reg; end
            4'd7: begin op_a = du2_reg;    op_b = dv1_reg; end
            default: ;
        endcase
    end

    logic [MB-1:0] abs_a, abs_b;
    assign abs_a    = op_a[DB-1] ? MB'(-op_a) : MB'(op_a);
    assign abs_b    = op_b[DB-1] ? MB'(-op_b) : MB'(op_b);
    assign neg_prod = op_a[DB-1] ^ op_b[DB-1];

    logic signed [TB-1:0] prod_s;
    assign prod_s = neg_prod ? -$signed({{(TB-PB){1'b0}}, mul_p[PB-1:0]})
                             :  $signed({{(TB-PB){1'b0}}, mul_p[PB-1:0]});

    // normalize shift
    logic [TB-1:0] mx;
    assign mx = (mag_reg[0] > mag_reg[1])
              ? ((mag_reg[0] > mag_reg[2]) ? mag_reg[0] : mag_reg[2])
              : ((mag_reg[1] > mag_reg[2]) ? mag_reg[1] : mag_reg[2]);

    logic sq_phase; // squares reuse step_reg 0..2

    always_comb
    begin
        st_next     = st_reg;
        cc_next     = cc_reg;
        step_next   = step_reg;
        k_next      = k_reg;
        status_next = status_reg;
        det_next    = det_reg;
        mul_a       = '0;
        mul_b       = '0;
        sq_phase    = 1'b0;
        case (st_reg)
            ttv_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    if (cc_reg == 2'd2)
                    begin
                        cc_next   = 2'd0;
                        step_next = '0;
                        st_next   = ttv_pkg::ST_MUL;
                    end
                    else
                        cc_next = cc_reg + 2'd1;
                end
            end
            ttv_pkg::ST_MUL:
            begin
                mul_a = 32'(abs_a);
                mul_b = 32'(abs_b);
                if (mul_done)
                begin
                    if (step_reg == 4'd7)
                    begin
                        det_next = det_reg - prod_s;
                        st_next  = ttv_pkg::ST_NORM;
                    end
                    step_next = step_reg + 4'd1;
                end
            end
            ttv_pkg::ST_NORM:
            begin
                if (det_reg == '0)
                begin
                    status_next = ttv_pkg::StatDetZero;
                    k_next      = 2'd0;
                    st_next     = ttv_pkg::ST_EMIT;
                end
                else if (mx == '0)
                begin
                    status_next = ttv_pkg::StatLenZero;
                    k_next      = 2'd0;
                    st_next     = ttv_pkg::ST_EMIT;
                end
                else if (mx[TB-1:30] == '0 && mx[29])
                begin
                    status_next = ttv_pkg::StatOk;
                    step_next   = '0;
                    st_next     = ttv_pkg::ST_SQ;
                end
            end
            ttv_pkg::ST_SQ:
            begin
                sq_phase = 1'b1;
                mul_a = mag_reg[step_reg[1:0]][31:0];
                mul_b = mag_reg[step_reg[1:0]][31:0];
                if (mul_done)
                begin
                    step_next = step_reg + 4'd1;
                    if (step_reg == 4'd2)
                        st_next = ttv_pkg::ST_SQRT;
                end
            end
            ttv_pkg::ST_SQRT:
            begin
                if (sd_done)
                begin
                    k_next  = 2'd0;
                    st_next = ttv_pkg::ST_DIV;
                end
            end
            ttv_pkg::ST_DIV:
            begin
                if (sd_done)
                begin
                    if (k_reg == 2'd2)
                    begin
                        k_next  = 2'd0;
                        st_next = ttv_pkg::ST_EMIT;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
            end
            ttv_pkg::ST_EMIT:
            begin
                if (tangent.ready)
                begin
                    if (k_reg == 2'd2)
                    begin
                        k_next  = 2'd0;
                        st_next = ttv_pkg::ST_IDLE;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
            end
            default: st_next = ttv_pkg::ST_IDLE;
        endcase
    end

    // launch pulses, registered in the cycle after entering/advancing
    logic launch_reg, launch_next;
    always_comb
    begin
        launch_next = 1'b0;
        if ((st_next == ttv_pkg::ST_MUL || st_next == ttv_pkg::ST_SQ) &&
            (st_next != st_reg || mul_done))
            launch_next = 1'b1;
        if (st_next == ttv_pkg::ST_SQRT && st_reg != ttv_pkg::ST_SQRT)
            launch_next = 1'b1;
        if (st_next == ttv_pkg::ST_DIV && (st_reg != ttv_pkg::ST_DIV || sd_done))
            launch_next = 1'b1;
    end

    logic mul_go, sqrt_go, div_go;
    assign mul_go  = launch_reg && (st_reg == ttv_pkg::ST_MUL || st_reg == ttv_pkg::ST_SQ);
    assign sqrt_go = launch_reg && (st_reg == ttv_pkg::ST_SQRT);
    assign div_go  = launch_reg && (st_reg == ttv_pkg::ST_DIV);

    // vertex index reduction: restoring remainder, one index bit per cycle,
    // all three indices at once while the products run
    logic [IdxB-1:0] vrem_reg [3], vrem_next [3];
    logic [IdxB-1:0] vsrc_reg [3], vsrc_next [3];
    logic [IdxB:0]   vtrial [3];
    logic [4:0]      vcnt_reg, vcnt_next;

    always_comb
    begin
        vcnt_next = vcnt_reg;
        for (int i = 0; i < 3; i++)
        begin
            vrem_next[i] = vrem_reg[i];
            vsrc_next[i] = vsrc_reg[i];
            vtrial[i]    = {vrem_reg[i], vsrc_reg[i][IdxB-1]};
        end
        if (take && cc_reg == 2'd2)
        begin
            vsrc_next[0] = hi_reg[0];
            vsrc_next[1] = hi_reg[1];
            vsrc_next[2] = corner.vtx_index;
            for (int i = 0; i < 3; i++)
                vrem_next[i] = '0;
            vcnt_next = 5'(IdxB);
        end
        else if (vcnt_reg != '0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vsrc_next[i] = vsrc_reg[i] << 1;
                if (vtrial[i] >= VertMod)
                    vrem_next[i] = IdxB'(vtrial[i] - VertMod);
                else
                    vrem_next[i] = IdxB'(vtrial[i]);
            end
            vcnt_next = vcnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ttv_pkg::ST_IDLE;
            cc_reg     <= 2'd0;
            step_reg   <= '0;
            k_reg      <= '0;
            launch_reg <= 1'b0;
            status_reg <= ttv_pkg::StatOk;
            vcnt_reg   <= '0;
        end
        else
        begin
            st_reg     <= st_next;
            cc_reg     <= cc_next;
            step_reg   <= step_next;
            k_reg      <= k_next;
            launch_reg <= launch_next;
            status_reg <= status_next;
            vcnt_reg   <= vcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            vrem_reg[i] <= vrem_next[i];
            vsrc_reg[i] <= vsrc_next[i];
        end
    end

    // payload datapath
    always_ff @(posedge clk)
    begin
        if (take && cc_reg != 2'd2)
        begin
            for (int i = 0; i < 3; i++)
                hp_reg[cc_reg[0]][i] <= cp[i];
            ht_reg[cc_reg[0]][0] <= ct[0];
            ht_reg[cc_reg[0]][1] <= ct[1];
            hi_reg[cc_reg[0]]    <= corner.vtx_index;
        end
        if (take && cc_reg == 2'd2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dp1_reg[i] <= DB'(hp_reg[1][i]) - DB'(hp_reg[0][i]);
                dp2_reg[i] <= DB'(cp[i]) - DB'(hp_reg[0][i]);
                t_reg[i]   <= '0;
            end
            du1_reg <= DB'(ht_reg[1][0]) - DB'(ht_reg[0][0]);
            dv1_reg <= DB'(ht_reg[1][1]) - DB'(ht_reg[0][1]);
            du2_reg <= DB'(ct[0]) - DB'(ht_reg[0][0]);
            dv2_reg <= DB'(ct[1]) - DB'(ht_reg[0][1]);
            det_reg <= '0;
        end
        if (st_reg == ttv_pkg::ST_MUL && mul_done)
        begin
            if (step_reg < 4'd6)
            begin
                if (step_reg[0])
                    t_reg[step_reg[2:1]] <= t_reg[step_reg[2:1]] - prod_s;
                else
                    t_reg[step_reg[2:1]] <= t_reg[step_reg[2:1]] + prod_s;
            end
            else if (step_reg == 4'd6)
                det_reg <= prod_s;
            else
            begin
                det_reg <= det_next;
                // magnitudes of sign-corrected T
                for (int i = 0; i < 3; i++)
                    mag_reg[i] <= t_reg[i][TB-1] ? TB'(-t_reg[i]) : TB'(t_reg[i]);
            end
        end
        if (st_reg == ttv_pkg::ST_NORM && det_reg != '0 && mx != '0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (mx[TB-1:30] != '0)
                    mag_reg[i] <= mag_reg[i] >> 1;
                else if (!mx[29])
                    mag_reg[i] <= mag_reg[i] << 1;
            end
            sum_reg <= '0;
        end
        if (sq_phase && mul_done)
            sum_reg <= sum_reg + mul_p;
        if (st_reg == ttv_pkg::ST_SQRT && sd_done)
            len_reg <= sd_res;
        if (st_reg == ttv_pkg::ST_NORM)
            for (int i = 0; i < 3; i++)
                res_reg[i] <= '0;
        if (st_reg == ttv_pkg::ST_DIV && sd_done)
            res_reg[k_reg] <= (t_reg[k_reg][TB-1] ^ det_reg[TB-1])
                            ? 16'(-sd_res) : 16'(sd_res);
    end

    // sign of t after det correction is t sign xor det sign; mag is unaffected
    assign sd_sqrt = sqrt_go;
    assign sd_div  = div_go;
    assign mul_start = mul_go;

    assign tangent.valid      = (st_reg == ttv_pkg::ST_EMIT);
    assign tangent.out_vertex = vrem_reg[k_reg];
    assign tangent.tan_x      = res_reg[0];
    assign tangent.tan_y      = res_reg[1];
    assign tangent.tan_z      = res_reg[2];
    assign tangent.status     = status_reg;
    assign tangent.last       = (k_reg == 2'd2);
endmodule

// ===== hdl/ttv_serial_mul.sv =====
// ----------------------------------------------------------------------------
// ttv_serial_mul: bit-serial unsigned multiplier
// Shift-and-add, one multiplier bit per cycle; product = a * b.
// ----------------------------------------------------------------------------
module ttv_serial_mul #(
    parameter int ABits = 34,
    parameter int BBits = 34
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [ABits-1:0]       a,
    input  logic [BBits-1:0]       b,
    output logic                   done,
    output logic [ABits+BBits-1:0] product
);
    localparam int CntBits = $clog2(BBits + 1);

    logic [ABits+BBits-1:0] acc_reg, acc_next;
    logic [ABits+BBits-1:0] a_reg, a_next;
    logic [BBits-1:0]       b_reg, b_next;
    logic [CntBits-1:0]     cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            acc_next  = '0;
            a_next    = {{BBits{1'b0}}, a};
            b_next    = b;
            cnt_next  = CntBits'(BBits);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_next = acc_reg + a_reg;
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntBits'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done    = busy_reg && (cnt_reg == CntBits'(1));
    assign product = acc_next;
endmodule

// ===== hdl/ttv_sqrt_div.sv =====
// ----------------------------------------------------------------------------
// ttv_sqrt_div: shared digit recurrence unit
// Restoring square root (one result bit per cycle) or restoring division
// with round-to-nearest offset (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module ttv_sqrt_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start_sqrt,
    input  logic        start_div,
    input  logic [63:0] radicand,
    input  logic [31:0] dividend_mag,   // |c| < 2^30
    input  logic [31:0] divisor,        // L, nonzero
    output logic        done,
    output logic [31:0] result
);
    logic [63:0] x_reg, x_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic [45:0] num_reg, num_next;
    logic [31:0] den_reg, den_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        mode_reg, mode_next;   // 0 sqrt, 1 divide
    logic [32:0] trial;
    logic [63:0] rb;

    always_comb
    begin
        x_next = x_reg; r_next = r_reg; bit_next = bit_reg;
        num_next = num_reg; den_next = den_reg; rem_next = rem_reg;
        q_next = q_reg; cnt_next = cnt_reg; busy_next = busy_reg;
        mode_next = mode_reg;
        rb    = r_reg + bit_reg;
        trial = {rem_reg[31:0], num_reg[45]};
        if (start_sqrt)
        begin
            x_next = radicand; r_next = '0; bit_next = 64'd1 << 62;
            cnt_next = 6'd32; busy_next = 1'b1; mode_next = 1'b0;
        end
        else if (start_div)
        begin
            // numerator = |c|*16384 + L/2 < 2^45
            num_next  = {dividend_mag[31:0], 14'd0} + {15'd0, divisor[31:1]};
            den_next  = divisor; rem_next = '0; q_next = '0;
            cnt_next  = 6'd46; busy_next = 1'b1; mode_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
            if (!mode_reg)
            begin
                if (x_reg >= rb)
                begin
                    x_next = x_reg - rb;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                    r_next = r_reg >> 1;
                bit_next = bit_reg >> 2;
            end
            else
            begin
                num_next = num_reg << 1;
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = trial - {1'b0, den_reg};
                    q_next   = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    q_next   = {q_reg[30:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next; r_reg <= r_next; bit_reg <= bit_next;
        num_reg <= num_next; den_reg <= den_next; rem_reg <= rem_next;
        q_reg <= q_next;
    end

    assign done   = busy_reg && (cnt_reg == 6'd1);
    assign result = mode_reg ? q_next : r_next[31:0];
endmodule

// ===== hdl/ttv_checker.sv =====
// ----------------------------------------------------------------------------
// ttv_checker: port-level checks of the tangent unit
// Watches the two channels and flags ordering slips, dropped results and bad status codes.
// ----------------------------------------------------------------------------
module ttv_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           out_last,
    input logic [ttv_pkg::StatusBits-1:0] out_status
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("corner taken during result");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status == ttv_pkg::StatOk ||
                       out_status == ttv_pkg::StatDetZero ||
                       out_status == ttv_pkg::StatLenZero)) else $error("bad status");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_last))
        else $error("result dropped");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid)
        else $error("result after last");
endmodule

bind triangle_tangent_vector_unit ttv_checker u_ttv_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(corner.valid), .in_ready(corner.ready),
    .out_valid(tangent.valid), .out_ready(tangent.ready),
    .out_last(tangent.last), .out_status(tangent.status)
);
